>>> src/hds_pkg.sv
// Shared types and constants for the heat diffusion stencil step.
// Used by every module of the block but hds_ram; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

	// Grid and field sizes
	localparam int MAX_COLS   = 64;
	localparam int MAX_ROWS   = 4096;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 12;
	localparam int VAL_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int ROWCNT_W   = 13;
	localparam int COLCNT_W   = 7;

	// Arithmetic widths: stencil sum, gain product, floored quotient, final sum before clipping
	localparam int DIFF_W     = VAL_W + 3;
	localparam int PROD_W     = DIFF_W + GAIN_W + 1;
	localparam int QUOT_W     = PROD_W - GAIN_W;
	localparam int SUM_W      = QUOT_W + 1;

	// Configuration port
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_ROWS = 2'd1;
	localparam logic [1:0] REG_COLS = 2'd2;

	localparam logic [GAIN_W-1:0]   GAIN_RST = GAIN_W'(13107);
	localparam logic [ROWCNT_W-1:0] ROWS_RST = ROWCNT_W'(64);
	localparam logic [COLCNT_W-1:0] COLS_RST = COLCNT_W'(64);

	localparam logic [ROWCNT_W-1:0] ROWS_MIN = ROWCNT_W'(3);
	localparam logic [ROWCNT_W-1:0] ROWS_MAX = ROWCNT_W'(MAX_ROWS);
	localparam logic [COLCNT_W-1:0] COLS_MIN = COLCNT_W'(3);
	localparam logic [COLCNT_W-1:0] COLS_MAX = COLCNT_W'(MAX_COLS);

	// 1.0 in signed Q2.30
	localparam logic [VAL_W-1:0] VAL_ONE = VAL_W'(1) << (VAL_W - 2);

	typedef logic signed [VAL_W-1:0] value_t;

	// Per-cell control that travels with a cell down the pipeline
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             top;
		logic             interior;
		logic             wrap;
		logic             bottom;
		logic             first;
		logic             last;
		logic             done;
	} item_ctl_t;

endpackage

`default_nettype wire

>>> src/hds_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; holds read data until the next read enable.
`timescale 1ns / 1ps
`default_nettype none

module hds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/hds_pipe.sv
// Stencil arithmetic pipeline: window registers, sum, gain product, clipping.
// Uses hds_pkg; row store read data comes from the top level.
`timescale 1ns / 1ps
`default_nettype none

module hds_pipe (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [hds_pkg::GAIN_W-1:0]    gain,
	// cell entering stage 1 (store reads issued in the same cycle)
	input  wire logic                          cell_load,
	input  wire hds_pkg::item_ctl_t            cell_ctl,
	input  wire hds_pkg::value_t               cell_x,
	output logic                               cell_ready,
	input  wire hds_pkg::value_t               rd_up,
	input  wire hds_pkg::value_t               rd_mid,
	// row store write-back
	output logic                               wr_en,
	output logic [hds_pkg::COL_W-1:0]          wr_addr,
	output hds_pkg::value_t                    wr_up_data,
	output hds_pkg::value_t                    wr_mid_data,
	// finished cell toward the emitter
	output logic                               res_valid,
	output hds_pkg::item_ctl_t                 res_ctl,
	output hds_pkg::value_t                    res_value,
	input  wire logic                          res_ready
);
	import hds_pkg::*;

	logic       valid_s1, valid_s2, valid_s3;
	item_ctl_t  ctl_s1, ctl_s2, ctl_s3;
	value_t     x_s1;
	value_t     centre_s2, centre_s3;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [PROD_W-1:0] prod_s3;

	value_t prev_right_q, prev_centre_q;

	logic ready_s1, ready_s2, ready_s3;
	logic fire_s1, fire_s2;

	logic signed [DIFF_W-1:0] up_e, down_e, left_e, right_e, centre_e, diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [QUOT_W-1:0] quot;
	logic signed [SUM_W-1:0]  sum;
	logic                     ovf_hi, ovf_lo;

	// Stage handshake: a stage moves when the next one is empty or moving
	assign ready_s3   = !valid_s3 || res_ready;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign fire_s1    = valid_s1 && ready_s2;
	assign fire_s2    = valid_s2 && ready_s3;
	assign cell_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= cell_load;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: hold the cell while its store reads come back
	always_ff @(posedge clk) begin
		if (cell_load && ready_s1) begin
			ctl_s1 <= cell_ctl;
			x_s1   <= cell_x;
		end
	end

	// Window along the previous row: right of cell j-1 is centre of cell j
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			prev_right_q  <= rd_mid;
			prev_centre_q <= prev_right_q;
		end
	end

	// Write back: old middle row shifts to upper, new cell into middle
	assign wr_en       = fire_s1;
	assign wr_addr     = ctl_s1.col;
	assign wr_up_data  = prev_right_q;
	assign wr_mid_data = x_s1;

	// Five-point sum: up + down + left + right - 4 * centre
	always_comb begin
		up_e     = $signed({{(DIFF_W-VAL_W){rd_up[VAL_W-1]}}, rd_up});
		down_e   = $signed({{(DIFF_W-VAL_W){x_s1[VAL_W-1]}}, x_s1});
		left_e   = $signed({{(DIFF_W-VAL_W){prev_centre_q[VAL_W-1]}}, prev_centre_q});
		right_e  = $signed({{(DIFF_W-VAL_W){rd_mid[VAL_W-1]}}, rd_mid});
		centre_e = $signed({{(DIFF_W-VAL_W){prev_right_q[VAL_W-1]}}, prev_right_q});
		diff     = up_e + down_e + left_e + right_e - (centre_e <<< 2);
	end

	// Stage 2: register the sum
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			ctl_s2    <= ctl_s1;
			centre_s2 <= prev_right_q;
			diff_s2   <= diff;
		end
	end

	// Gain product
	assign prod = $signed({1'b0, gain}) * diff_s2;

	// Stage 3: register the product
	always_ff @(posedge clk) begin
		if (fire_s2) begin
			ctl_s3    <= ctl_s2;
			centre_s3 <= centre_s2;
			prod_s3   <= prod;
		end
	end

	// Floor the product, add centre, clip to the value range
	always_comb begin
		quot   = $signed(prod_s3[PROD_W-1:GAIN_W]);
		sum    = $signed({{(SUM_W-VAL_W){centre_s3[VAL_W-1]}}, centre_s3})
		       + $signed({quot[QUOT_W-1], quot});
		ovf_hi = !sum[SUM_W-1] && (|sum[SUM_W-2:VAL_W-1]);
		ovf_lo = sum[SUM_W-1] && !(&sum[SUM_W-2:VAL_W-1]);
		if (ovf_hi) begin
			res_value = $signed({1'b0, {(VAL_W-1){1'b1}}});
		end else if (ovf_lo) begin
			res_value = $signed({1'b1, {(VAL_W-1){1'b0}}});
		end else begin
			res_value = $signed(sum[VAL_W-1:0]);
		end
	end

	assign res_valid = valid_s3;
	assign res_ctl   = ctl_s3;

endmodule

`default_nettype wire

>>> src/hds_emit.sv
// Result emitter: expands one finished cell into its results, one per cycle
// while result_stall allows, and drives the output register. Uses hds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hds_emit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// finished cell from the pipeline
	input  wire logic                        cell_valid_in,
	input  wire hds_pkg::item_ctl_t          cell_ctl,
	input  wire hds_pkg::value_t             cell_result,
	output logic                             cell_ready_out,
	// result channel
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [hds_pkg::ROW_W-1:0]        out_row,
	output logic [hds_pkg::COL_W-1:0]        out_column,
	output hds_pkg::value_t                  new_value,
	output logic                             grid_done
);
	import hds_pkg::*;

	// Pending result kinds, emitted lowest first
	localparam int B_TOP   = 0;
	localparam int B_STEN  = 1;
	localparam int B_WRAP0 = 2;
	localparam int B_WRAPN = 3;
	localparam int B_BOT   = 4;
	localparam int NKIND   = 5;

	logic [NKIND-1:0] pend_q, pend_clr, pend_after, pend_new;
	logic [ROW_W-1:0] row_q, row_m1;
	logic [COL_W-1:0] col_q;
	value_t           val_q, first_cap_q, last_cap_q;
	logic             done_q;
	value_t           first_q, last_q;

	logic             out_free, emit, hold_free, load;
	logic [ROW_W-1:0] n_row;
	logic [COL_W-1:0] n_col;
	value_t           n_val;
	logic             n_done;

	assign out_free = !result_valid || !result_stall;
	assign emit     = (pend_q != '0) && out_free;
	assign row_m1   = row_q - ROW_W'(1);

	// Pick the next result of the held cell
	always_comb begin
		pend_clr = '0;
		n_row    = row_m1;
		n_col    = col_q;
		n_val    = val_q;
		n_done   = 1'b0;
		priority if (pend_q[B_TOP]) begin
			pend_clr[B_TOP] = 1'b1;
			n_row = '0;
			n_val = '0;
		end else if (pend_q[B_STEN]) begin
			pend_clr[B_STEN] = 1'b1;
		end else if (pend_q[B_WRAP0]) begin
			pend_clr[B_WRAP0] = 1'b1;
			n_col = '0;
			n_val = last_cap_q;
		end else if (pend_q[B_WRAPN]) begin
			pend_clr[B_WRAPN] = 1'b1;
			n_val = first_cap_q;
		end else begin
			pend_clr[B_BOT] = pend_q[B_BOT];
			n_row  = row_q;
			n_val  = $signed(VAL_ONE);
			n_done = done_q;
		end
	end

	assign pend_after     = pend_q & ~pend_clr;
	assign hold_free      = (pend_q == '0) || (emit && (pend_after == '0));
	assign load           = cell_valid_in && hold_free;
	assign cell_ready_out = hold_free;

	assign pend_new = {cell_ctl.bottom, cell_ctl.wrap, cell_ctl.wrap,
	                   cell_ctl.interior, cell_ctl.top};

	// Pending mask: load a new cell or drop the result just sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= pend_new;
		end else if (emit) begin
			pend_q <= pend_after;
		end
	end

	// Hold the cell's payload
	always_ff @(posedge clk) begin
		if (load) begin
			row_q       <= cell_ctl.row;
			col_q       <= cell_ctl.col;
			val_q       <= cell_result;
			done_q      <= cell_ctl.done;
			first_cap_q <= first_q;
			last_cap_q  <= last_q;
		end
	end

	// Track first and last interior results of the row in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q  <= '0;
		end else if (load && cell_ctl.interior) begin
			if (cell_ctl.first) first_q <= cell_result;
			if (cell_ctl.last)  last_q  <= cell_result;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_row    <= n_row;
			out_column <= n_col;
			new_value  <= n_val;
			grid_done  <= n_done;
		end
	end

endmodule

`default_nettype wire

>>> src/heat_diffusion_stencil_step.sv
// Top level of the streaming five-point diffusion step: configuration
// registers, grid position, the two row stores and the block's channels.
// Depends on hds_pkg, hds_ram, hds_pipe and hds_emit.
//
//   channel   direction  handshake                 payload
//   cell      in         cell_valid / cell_stall     cell_value
//   result    out        result_valid / result_stall out_row, out_column,
//                                                    new_value, grid_done
//   config    in         APB write/read              paddr, pwdata, prdata
//
// One cell is taken per cycle while cell_stall is low. A cell that yields extra
// results (up to two) holds the input back, since the output register sends at
// most one result per cycle. A cell's results pass stage 1, the sum and product
// registers, the emitter's hold register and the output register. The row stores
// need no clearing after reset; every pass starts at row 0. Stalls on the result
// side back up through the pipeline registers before they reach cell_stall.
`timescale 1ns / 1ps
`default_nettype none

module heat_diffusion_stencil_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// cell channel
	input  wire logic                          cell_valid,
	output logic                               cell_stall,
	input  wire logic signed [hds_pkg::VAL_W-1:0] cell_value,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [hds_pkg::ROW_W-1:0]          out_row,
	output logic [hds_pkg::COL_W-1:0]          out_column,
	output logic signed [hds_pkg::VAL_W-1:0]   new_value,
	output logic                               grid_done,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [hds_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [hds_pkg::PDATA_W-1:0]   pwdata,
	output logic [hds_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);
	import hds_pkg::*;

	logic [GAIN_W-1:0]   gain_q;
	logic [ROWCNT_W-1:0] row_count_q, rows_eff;
	logic [COLCNT_W-1:0] col_count_q, cols_eff;
	logic [ROW_W-1:0]    rows_m1;
	logic [COL_W-1:0]    cols_m1;

	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;

	logic [1:0]          reg_idx;
	logic                cfg_wr, pos_clr;

	logic                cell_ready, accept;
	item_ctl_t           ctl;
	logic                row_ge2;
	logic [COL_W-1:0]    mid_raddr;

	value_t              rd_up, rd_mid, wr_up_data, wr_mid_data;
	logic                wr_en;
	logic [COL_W-1:0]    wr_addr;

	logic                res_valid, res_ready;
	item_ctl_t           res_ctl;
	value_t              res_value;

	// Configuration writes
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pos_clr = cfg_wr && ((reg_idx == REG_ROWS) || (reg_idx == REG_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q      <= GAIN_RST;
			row_count_q <= ROWS_RST;
			col_count_q <= COLS_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_GAIN: gain_q      <= pwdata[GAIN_W-1:0];
				REG_ROWS: row_count_q <= pwdata[ROWCNT_W-1:0];
				REG_COLS: col_count_q <= pwdata[COLCNT_W-1:0];
				default:  ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (reg_idx)
			REG_GAIN: prdata = PDATA_W'(gain_q);
			REG_ROWS: prdata = PDATA_W'(row_count_q);
			REG_COLS: prdata = PDATA_W'(col_count_q);
			default:  prdata = '0;
		endcase
	end

	// Clamp the geometry into the supported range
	always_comb begin
		if (row_count_q < ROWS_MIN)      rows_eff = ROWS_MIN;
		else if (row_count_q > ROWS_MAX) rows_eff = ROWS_MAX;
		else                             rows_eff = row_count_q;
		if (col_count_q < COLS_MIN)      cols_eff = COLS_MIN;
		else if (col_count_q > COLS_MAX) cols_eff = COLS_MAX;
		else                             cols_eff = col_count_q;
	end
	assign rows_m1 = ROW_W'(rows_eff - ROWCNT_W'(1));
	assign cols_m1 = COL_W'(cols_eff - COLCNT_W'(1));

	// Cell transfer
	assign cell_stall = !cell_ready;
	assign accept     = cell_valid && cell_ready;

	// Grid position of the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pos_clr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == cols_m1) begin
				col_q <= '0;
				row_q <= (row_q == rows_m1) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Classify the cell by the results it produces
	assign row_ge2 = (row_q > ROW_W'(1));
	always_comb begin
		ctl.row      = row_q;
		ctl.col      = col_q;
		ctl.top      = (row_q == '0);
		ctl.interior = row_ge2 && (col_q != '0) && (col_q != cols_m1);
		ctl.wrap     = row_ge2 && (col_q == cols_m1);
		ctl.bottom   = (row_q == rows_m1);
		ctl.first    = (col_q == COL_W'(1));
		ctl.last     = (col_q == cols_m1 - COL_W'(1));
		ctl.done     = (row_q == rows_m1) && (col_q == cols_m1);
	end

	// Middle store is read one column ahead; the row end fetches column 0
	assign mid_raddr = (col_q == cols_m1) ? '0 : col_q + COL_W'(1);

	hds_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_COLS)
	) u_upper_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_up_data),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_up)
	);

	hds_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_COLS)
	) u_middle_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_mid_data),
		.re    (accept),
		.raddr (mid_raddr),
		.rdata (rd_mid)
	);

	hds_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.gain        (gain_q),
		.cell_load   (accept),
		.cell_ctl    (ctl),
		.cell_x      (cell_value),
		.cell_ready  (cell_ready),
		.rd_up       (rd_up),
		.rd_mid      (rd_mid),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_up_data  (wr_up_data),
		.wr_mid_data (wr_mid_data),
		.res_valid   (res_valid),
		.res_ctl     (res_ctl),
		.res_value   (res_value),
		.res_ready   (res_ready)
	);

	hds_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.cell_valid_in  (res_valid),
		.cell_ctl       (res_ctl),
		.cell_result    (res_value),
		.cell_ready_out (res_ready),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_row        (out_row),
		.out_column     (out_column),
		.new_value      (new_value),
		.grid_done      (grid_done)
	);

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking bench for the streaming five-point diffusion step: random and directed
// grids go in through the cell channel and each new cell is checked against a predictor.
// Depends on hds_pkg and heat_diffusion_stencil_step.
`timescale 1ns / 1ps

module tb_top;
	import hds_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_CELLS = 220;
	localparam int REPORT_LIMIT = 10;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
	localparam value_t VALUE_MIN = 32'sh8000_0000;

	typedef struct {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		value_t           value;
		logic             done;
	} new_cell_t;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// Block ports
	logic                cell_valid = 1'b0;
	logic                cell_stall;
	value_t              cell_value = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	logic [ROW_W-1:0]    out_row;
	logic [COL_W-1:0]    out_column;
	value_t              new_value;
	logic                grid_done;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	heat_diffusion_stencil_step DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.cell_value   (cell_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_row      (out_row),
		.out_column   (out_column),
		.new_value    (new_value),
		.grid_done    (grid_done),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Shadow registers and predictor state
	logic [GAIN_W-1:0]   gain_reg = GAIN_RST;
	logic [ROWCNT_W-1:0] rows_reg = ROWS_RST;
	logic [COLCNT_W-1:0] cols_reg = COLS_RST;
	value_t              upper_line [MAX_COLS];
	value_t              middle_line [MAX_COLS];
	int unsigned         cur_row = 0;
	int unsigned         cur_col = 0;
	value_t              first_inner = '0;
	value_t              last_inner = '0;

	value_t    cell_backlog [$];
	new_cell_t expected_cells [$];
	int        cells_queued = 0;
	int        cells_taken = 0;
	int        random_cells = 0;
	int        error_count = 0;
	int        cycle_count = 0;
	logic      calm = 1'b0;

	function automatic int unsigned grid_rows();
		if (rows_reg < ROWS_MIN)
			return ROWS_MIN;
		if (rows_reg > ROWS_MAX)
			return ROWS_MAX;
		return rows_reg;
	endfunction

	function automatic int unsigned grid_cols();
		if (cols_reg < COLS_MIN)
			return COLS_MIN;
		if (cols_reg > COLS_MAX)
			return COLS_MAX;
		return cols_reg;
	endfunction

	task automatic note_error(string text);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, text);
	endtask

	// Explicit step: centre plus floored gain times Laplacian, clipped to 32 bits
	function automatic value_t diffuse(value_t up, value_t down, value_t left, value_t right,
			value_t centre);
		longint lap;
		longint prod;
		longint total;
		lap = longint'(up) + longint'(down) + longint'(left) + longint'(right)
			- 4 * longint'(centre);
		prod = longint'(gain_reg) * lap;
		total = longint'(centre) + (prod >>> 16);
		if (total > longint'(VALUE_MAX))
			return VALUE_MAX;
		if (total < longint'(VALUE_MIN))
			return VALUE_MIN;
		return value_t'(total);
	endfunction

	task automatic expect_cell(int unsigned r, int unsigned c, value_t v, logic done);
		expected_cells.push_back(new_cell_t'{row: ROW_W'(r), col: COL_W'(c), value: v,
			done: done});
	endtask

	// Work out the new cells released by one old cell and advance the grid position
	task automatic predict_cell(value_t x);
		int unsigned nrows;
		int unsigned ncols;
		int unsigned r;
		int unsigned j;
		value_t v;
		nrows = grid_rows();
		ncols = grid_cols();
		r = (cur_row >= nrows) ? nrows - 1 : cur_row;
		j = (cur_col >= ncols) ? ncols - 1 : cur_col;
		if (r == 0)
			expect_cell(0, j, '0, 1'b0);
		if (r >= 2 && j >= 1 && j <= ncols - 2) begin
			v = diffuse(upper_line[j], x, upper_line[j-1], middle_line[j+1], middle_line[j]);
			if (j == 1)
				first_inner = v;
			if (j == ncols - 2)
				last_inner = v;
			expect_cell(r - 1, j, v, 1'b0);
		end
		if (r >= 2 && j == ncols - 1) begin
			expect_cell(r - 1, 0, last_inner, 1'b0);
			expect_cell(r - 1, ncols - 1, first_inner, 1'b0);
		end
		if (r == nrows - 1)
			expect_cell(nrows - 1, j, VAL_ONE, j == ncols - 1);
		upper_line[j] = middle_line[j];
		middle_line[j] = x;
		if (j + 1 >= ncols) begin
			cur_col = 0;
			cur_row = (r + 1 >= nrows) ? 0 : r + 1;
		end else begin
			cur_col = j + 1;
			cur_row = r;
		end
	endtask

	// Cell driver: hold the payload while stalled, idle now and then
	always @(posedge clk) begin : drive_cells
		logic hold_off;
		if (!arst_n) begin
			cell_valid <= 1'b0;
		end else begin
			if (cell_valid && !cell_stall) begin
				predict_cell(cell_value);
				cells_taken++;
			end
			if (!cell_valid || !cell_stall) begin
				hold_off = !calm && ($urandom_range(0, 99) < 9);
				if (!hold_off && cell_backlog.size() > 0) begin
					cell_valid <= 1'b1;
					cell_value <= cell_backlog.pop_front();
				end else begin
					cell_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest expected cell
	always @(posedge clk) begin : watch_results
		new_cell_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_cells.size() == 0) begin
					note_error($sformatf("unexpected result row %0d col %0d value %h done %b",
						out_row, out_column, new_value, grid_done));
				end else begin
					want = expected_cells.pop_front();
					if (out_row !== want.row || out_column !== want.col
							|| new_value !== want.value || grid_done !== want.done)
						note_error($sformatf(
							"got row %0d col %0d value %h done %b, want row %0d col %0d value %h done %b",
							out_row, out_column, new_value, grid_done,
							want.row, want.col, want.value, want.done));
				end
			end
			result_stall <= !calm && ($urandom_range(0, 99) < 9);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] index, logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Mirror the write; a geometry change restarts the grid
		case (index)
			REG_GAIN: gain_reg = data[GAIN_W-1:0];
			REG_ROWS: begin
				rows_reg = data[ROWCNT_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			REG_COLS: begin
				cols_reg = data[COLCNT_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			default: ;
		endcase
	endtask

	task automatic check_register(logic [1:0] index, logic [PDATA_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {index, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (prdata !== want)
			note_error($sformatf("register %0d read %h, want %h", index, prdata, want));
	endtask

	task automatic check_registers();
		check_register(REG_GAIN, PDATA_W'(gain_reg));
		check_register(REG_ROWS, PDATA_W'(rows_reg));
		check_register(REG_COLS, PDATA_W'(cols_reg));
	endtask

	task automatic set_grid(int unsigned gain, int unsigned rows, int unsigned cols);
		reg_write(REG_GAIN, PDATA_W'(gain));
		reg_write(REG_ROWS, PDATA_W'(rows));
		reg_write(REG_COLS, PDATA_W'(cols));
	endtask

	// Wait until every cell is taken and every new cell has come, then let the pipe drain
	task automatic wait_idle();
		while (cells_taken != cells_queued || expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_value(value_t v);
		cell_backlog.push_back(v);
		cells_queued++;
	endtask

	function automatic value_t random_cell();
		case ($urandom_range(0, 19))
			0: return VALUE_MAX;
			1: return VALUE_MIN;
			2: return '0;
			3: return VAL_ONE;
			4: return value_t'(-1);
			5, 6, 7, 8, 9: return value_t'($urandom);
			default: return value_t'($urandom_range(0, VAL_ONE));
		endcase
	endfunction

	task automatic queue_cells(int count);
		repeat (count) begin
			queue_value(random_cell());
			random_cells++;
		end
	endtask

	initial begin : stimulus
		int unsigned gain;
		int unsigned rows;
		int unsigned cols;
		int cells;
		int half;
		for (int i = 0; i < MAX_COLS; i++) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		// Two rows and a bit of the default grid, then cut short by a geometry write
		queue_cells(2 * MAX_COLS + 10);
		wait_idle();

		// Saturation: a low centre among high neighbors, then the reverse, at full gain
		set_grid(32'h0000_FFFF, 3, 3);
		check_registers();
		for (int i = 0; i < 9; i++)
			queue_value((i % 2 == 0) ? VALUE_MIN : VALUE_MAX);
		for (int i = 0; i < 9; i++)
			queue_value((i % 2 == 0) ? VALUE_MAX : VALUE_MIN);
		wait_idle();
		// Zero gain passes the centre through; a spare register write is ignored
		reg_write(REG_GAIN, 32'hA5A5_0000);
		reg_write(REG_SPARE, $urandom);
		queue_value(VAL_ONE);
		queue_value(value_t'(-1));
		queue_value('0);
		queue_value(VALUE_MAX);
		queue_value(value_t'(32'h2000_0000));
		queue_value(VALUE_MIN);
		queue_value(value_t'(-1));
		queue_value(VAL_ONE);
		queue_value('0);
		wait_idle();
		check_registers();

		// Random grids, mostly small; wide grids keep to the minimum row count
		while (random_cells < RANDOM_CELLS) begin
			case ($urandom_range(0, 5))
				0: gain = 0;
				1: gain = 16'hFFFF;
				default: gain = $urandom_range(0, 16'hFFFF);
			endcase
			case ($urandom_range(0, 9))
				0: cols = $urandom_range(13, 64);
				1: cols = $urandom_range(0, 2);
				2: cols = $urandom_range(65, 127);
				default: cols = $urandom_range(3, 12);
			endcase
			if (cols > 12)
				rows = $urandom_range(0, 3);
			else
				rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
			set_grid(gain, rows, cols);
			check_registers();
			cells = grid_rows() * grid_cols();
			case ($urandom_range(0, 7))
				0: queue_cells($urandom_range(1, cells - 1));
				1: queue_cells((cells > 48) ? cells : 2 * cells);
				2: begin
					half = cells / 2;
					queue_cells(half);
					wait_idle();
					reg_write(REG_GAIN, $urandom_range(0, 16'hFFFF));
					queue_cells(cells - half);
				end
				3: begin
					calm = 1'b1;
					queue_cells(cells);
					wait_idle();
					calm = 1'b0;
				end
				default: queue_cells(cells);
			endcase
			wait_idle();
		end

		// Widest grid: column count clamps to the maximum, row count to the minimum
		set_grid($urandom_range(0, 16'hFFFF), 0, 127);
		calm = 1'b1;
		queue_cells(grid_rows() * grid_cols());
		wait_idle();
		calm = 1'b0;

		// Tallest grid: an all-ones row count clamps to the maximum; run its first rows
		set_grid($urandom_range(0, 16'hFFFF), 13'h1FFF, 3);
		check_registers();
		queue_cells(4 * grid_cols());
		wait_idle();

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
src/hds_pkg.sv
src/hds_ram.sv
src/hds_pipe.sv
src/hds_emit.sv
src/heat_diffusion_stencil_step.sv
verif/tb_top.sv
